FILE: hdl/gsp_pkg.sv
package gsp_pkg;

  // Number of magic prefix bytes checked at the head of every blob (1 to 8).
  localparam int MAGIC_BYTES = 4;

  // Length of a node id in bytes.
  localparam int ID_LEN = 33;

  // Result queue depth; it must hold the two results of one byte.
  localparam int RES_DEPTH = 4;

  typedef enum logic [4:0] {
    PH_MAGIC  = 5'd0,
    PH_TS     = 5'd1,
    PH_NCOUNT = 5'd2,
    PH_NODEID = 5'd3,
    PH_CCOUNT = 5'd4,
    PH_SCID   = 5'd5,
    PH_FEAT   = 5'd6,
    PH_NODE1  = 5'd7,
    PH_NODE2  = 5'd8,
    PH_FUND   = 5'd9,
    PH_UCOUNT = 5'd10,
    PH_DIR    = 5'd11,
    PH_CLTV   = 5'd12,
    PH_HMIN   = 5'd13,
    PH_HMAX   = 5'd14,
    PH_FBASE  = 5'd15,
    PH_FPPM   = 5'd16,
    PH_FLAGS  = 5'd17,
    PH_UTS    = 5'd18
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_t;

  typedef enum logic [4:0] {
    FC_TIMESTAMP  = 5'd0,
    FC_NODE_COUNT = 5'd1,
    FC_NODE_ID    = 5'd2,
    FC_CHAN_COUNT = 5'd3,
    FC_SCID       = 5'd4,
    FC_FEATURES   = 5'd5,
    FC_NODE1      = 5'd6,
    FC_NODE2      = 5'd7,
    FC_FUNDING    = 5'd8,
    FC_UPD_COUNT  = 5'd9,
    FC_DIRECTION  = 5'd10,
    FC_CLTV       = 5'd11,
    FC_HTLC_MIN   = 5'd12,
    FC_HTLC_MAX   = 5'd13,
    FC_FEE_BASE   = 5'd14,
    FC_FEE_PPM    = 5'd15,
    FC_FLAGS      = 5'd16,
    FC_UPD_TS     = 5'd17
  } field_code_t;

  typedef enum logic [2:0] {
    ERR_BAD_MAGIC    = 3'd0,
    ERR_TRUNCATED    = 3'd1,
    ERR_NODE_OVER    = 3'd2,
    ERR_CHAN_OVER    = 3'd3,
    ERR_UPDATES_OVER = 3'd4
  } error_code_t;

  typedef enum logic [1:0] {
    CFG_MAGIC       = 2'd0,
    CFG_NODE_CAP    = 2'd1,
    CFG_CHAN_CAP    = 2'd2,
    CFG_MAX_UPDATES = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_blob;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic [23:0] node_index;
    logic [5:0]  id_byte_offset;
    logic [31:0] channel_index;
    logic [7:0]  update_index;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_beat_t;

  // Byte length of the field read in each phase.
  function automatic logic [5:0] field_len(input phase_t ph);
    logic [5:0] len;
    case (ph)
      PH_TS, PH_CCOUNT, PH_FBASE, PH_FPPM, PH_UTS: len = 6'd4;
      PH_NCOUNT, PH_NODE1, PH_NODE2:                len = 6'd3;
      PH_FEAT, PH_CLTV, PH_FLAGS:                   len = 6'd2;
      PH_SCID, PH_FUND, PH_HMIN, PH_HMAX:           len = 6'd8;
      PH_NODEID, PH_UCOUNT, PH_DIR:                 len = 6'd1;
      default:                                      len = 6'd0;
    endcase
    return len;
  endfunction

  // Field code reported when a phase completes.
  function automatic field_code_t phase_code(input phase_t ph);
    field_code_t fc;
    case (ph)
      PH_TS:     fc = FC_TIMESTAMP;
      PH_NCOUNT: fc = FC_NODE_COUNT;
      PH_NODEID: fc = FC_NODE_ID;
      PH_CCOUNT: fc = FC_CHAN_COUNT;
      PH_SCID:   fc = FC_SCID;
      PH_FEAT:   fc = FC_FEATURES;
      PH_NODE1:  fc = FC_NODE1;
      PH_NODE2:  fc = FC_NODE2;
      PH_FUND:   fc = FC_FUNDING;
      PH_UCOUNT: fc = FC_UPD_COUNT;
      PH_DIR:    fc = FC_DIRECTION;
      PH_CLTV:   fc = FC_CLTV;
      PH_HMIN:   fc = FC_HTLC_MIN;
      PH_HMAX:   fc = FC_HTLC_MAX;
      PH_FBASE:  fc = FC_FEE_BASE;
      PH_FPPM:   fc = FC_FEE_PPM;
      PH_FLAGS:  fc = FC_FLAGS;
      PH_UTS:    fc = FC_UPD_TS;
      default:   fc = FC_TIMESTAMP;
    endcase
    return fc;
  endfunction

  function automatic out_beat_t field_beat(input field_code_t fc, input logic [63:0] value,
                                           input logic [31:0] cidx, input logic [7:0] uidx);
    out_beat_t r;
    r = '0;
    r.result_kind   = KIND_FIELD;
    r.field_code    = fc;
    r.field_value   = value;
    r.channel_index = cidx;
    r.update_index  = uidx;
    return r;
  endfunction

  function automatic out_beat_t error_beat(input error_code_t err);
    out_beat_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = err;
    return r;
  endfunction

  function automatic out_beat_t done_beat();
    out_beat_t r;
    r = '0;
    r.result_kind = KIND_DONE;
    return r;
  endfunction

endpackage

FILE: hdl/gossip_snapshot_parser.sv
// Streaming parser for a compact gossip snapshot blob.
// The input channel (in_valid, in_stall, in_data) carries one blob byte per beat,
// with end_of_blob set on the final byte. The output channel (out_valid, out_stall,
// out_data) carries result beats: completed fields, done, or an error, with
// last_of_run marking the final result caused by one input byte.
// A byte is parsed in the cycle it is accepted and its results (zero, one or two)
// enter a four-entry registered result queue and reach out_data once the results
// ahead of them have left. One byte is accepted every cycle while the queue has
// room for two results, so the rate is one byte per cycle while in_stall stays
// low; the queue absorbs the extra entry of a byte that yields two results.
// When the receiver stalls, the queue fills and in_stall rises once fewer than
// two entries are free; out_data holds steady while out_stall is high.
// The configuration port (cfg_wr_en, cfg_addr, cfg_wr_data) writes the magic value
// and three limits, only while the parser is idle: a user rule, not enforced here.
// Reset (rst_n low, synchronous) empties the queue, returns the parse to the
// magic check and loads the register defaults. A byte with end_of_blob set also
// returns the parse to the magic check for the next blob.
module gossip_snapshot_parser
  import gsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_addr,
  input  logic [63:0] cfg_wr_data
);

  localparam logic [63:0] MagicMask =
    (MAGIC_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * MAGIC_BYTES)) - 64'd1);
  localparam int PtrW = $clog2(RES_DEPTH);
  localparam int CntW = $clog2(RES_DEPTH + 1);

  // Configuration registers.
  logic [63:0] magic_r;
  logic [23:0] node_limit_r;
  logic [31:0] chan_limit_r;
  logic [7:0]  max_upd_r;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  logic [5:0]  bif_r, bif_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [23:0] nodes_exp_r, nodes_exp_nxt;
  logic [23:0] nodes_seen_r, nodes_seen_nxt;
  logic [31:0] chans_exp_r, chans_exp_nxt;
  logic [31:0] chans_seen_r, chans_seen_nxt;
  logic [7:0]  upd_exp_r, upd_exp_nxt;
  logic [7:0]  upd_seen_r, upd_seen_nxt;
  logic        finished_r, finished_nxt;

  // Result queue.
  out_beat_t           queue_r [RES_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r, count_nxt;

  logic        in_accept;
  logic        out_pop;
  logic [63:0] acc_sh;
  logic [5:0]  bif_inc;
  logic [31:0] chans_inc;
  logic [7:0]  upd_inc;
  logic [23:0] nodes_inc;
  out_beat_t   res0, res1;
  logic [1:0]  res_n;

  assign in_stall  = (count_r > CntW'(RES_DEPTH - 2));
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = queue_r[rd_ptr_r];

  assign acc_sh    = {acc_r[55:0], in_data.data_byte};
  assign bif_inc   = bif_r + 6'd1;
  assign chans_inc = chans_seen_r + 32'd1;
  assign upd_inc   = upd_seen_r + 8'd1;
  assign nodes_inc = nodes_seen_r + 24'd1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r      <= '0;
      node_limit_r <= 24'hFFFFFF;
      chan_limit_r <= 32'hFFFFFFFF;
      max_upd_r    <= 8'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_addr))
        CFG_MAGIC:       magic_r      <= cfg_wr_data;
        CFG_NODE_CAP:    node_limit_r <= cfg_wr_data[23:0];
        CFG_CHAN_CAP:    chan_limit_r <= cfg_wr_data[31:0];
        CFG_MAX_UPDATES: max_upd_r    <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Per-byte parse step: next state and up to two results.
  always_comb begin
    phase_nxt      = phase_r;
    bif_nxt        = bif_r;
    acc_nxt        = acc_r;
    nodes_exp_nxt  = nodes_exp_r;
    nodes_seen_nxt = nodes_seen_r;
    chans_exp_nxt  = chans_exp_r;
    chans_seen_nxt = chans_seen_r;
    upd_exp_nxt    = upd_exp_r;
    upd_seen_nxt   = upd_seen_r;
    finished_nxt   = finished_r;
    res0           = '0;
    res1           = '0;
    res_n          = 2'd0;

    if (in_accept && !finished_r) begin
      case (phase_r)
        PH_MAGIC: begin
          if (bif_inc < 6'(MAGIC_BYTES)) begin
            acc_nxt = acc_sh;
            bif_nxt = bif_inc;
          end else begin
            acc_nxt = '0;
            bif_nxt = '0;
            if ((acc_sh & MagicMask) != (magic_r & MagicMask)) begin
              res0         = error_beat(ERR_BAD_MAGIC);
              res_n        = 2'd1;
              finished_nxt = 1'b1;
            end else begin
              phase_nxt = PH_TS;
            end
          end
        end
        PH_NODEID: begin
          // Each id byte is reported on its own.
          res0                = field_beat(FC_NODE_ID, {56'd0, in_data.data_byte}, '0, '0);
          res0.node_index     = nodes_seen_r;
          res0.id_byte_offset = bif_r;
          res_n               = 2'd1;
          acc_nxt             = '0;
          if (bif_inc >= 6'(ID_LEN)) begin
            bif_nxt        = '0;
            nodes_seen_nxt = nodes_inc;
            if (nodes_inc == nodes_exp_r) begin
              phase_nxt = PH_CCOUNT;
            end
          end else begin
            bif_nxt = bif_inc;
          end
        end
        default: begin
          if (bif_inc < field_len(phase_r)) begin
            acc_nxt = acc_sh;
            bif_nxt = bif_inc;
          end else begin
            // Field complete: report it, then follow the record structure.
            acc_nxt = '0;
            bif_nxt = '0;
            res0    = field_beat(phase_code(phase_r), acc_sh,
                                 (phase_r >= PH_SCID) ? chans_seen_r : 32'd0,
                                 (phase_r >= PH_DIR) ? upd_seen_r : 8'd0);
            res_n   = 2'd1;
            case (phase_r)
              PH_NCOUNT: begin
                nodes_exp_nxt  = acc_sh[23:0];
                nodes_seen_nxt = '0;
                if (acc_sh[23:0] > node_limit_r) begin
                  res1         = error_beat(ERR_NODE_OVER);
                  res_n        = 2'd2;
                  finished_nxt = 1'b1;
                end else if (acc_sh[23:0] == '0) begin
                  phase_nxt = PH_CCOUNT;
                end else begin
                  phase_nxt = PH_NODEID;
                end
              end
              PH_CCOUNT: begin
                chans_exp_nxt  = acc_sh[31:0];
                chans_seen_nxt = '0;
                if (acc_sh[31:0] > chan_limit_r) begin
                  res1         = error_beat(ERR_CHAN_OVER);
                  res_n        = 2'd2;
                  finished_nxt = 1'b1;
                end else if (acc_sh[31:0] == '0) begin
                  res1         = done_beat();
                  res_n        = 2'd2;
                  finished_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_SCID;
                end
              end
              PH_UCOUNT: begin
                upd_exp_nxt  = acc_sh[7:0];
                upd_seen_nxt = '0;
                if (acc_sh[7:0] > max_upd_r) begin
                  res1         = error_beat(ERR_UPDATES_OVER);
                  res_n        = 2'd2;
                  finished_nxt = 1'b1;
                end else if (acc_sh[7:0] == '0) begin
                  chans_seen_nxt = chans_inc;
                  if (chans_inc == chans_exp_r) begin
                    res1         = done_beat();
                    res_n        = 2'd2;
                    finished_nxt = 1'b1;
                  end else begin
                    phase_nxt = PH_SCID;
                  end
                end else begin
                  phase_nxt = PH_DIR;
                end
              end
              PH_UTS: begin
                upd_seen_nxt = upd_inc;
                if (upd_inc == upd_exp_r) begin
                  chans_seen_nxt = chans_inc;
                  if (chans_inc == chans_exp_r) begin
                    res1         = done_beat();
                    res_n        = 2'd2;
                    finished_nxt = 1'b1;
                  end else begin
                    phase_nxt = PH_SCID;
                  end
                end else begin
                  phase_nxt = PH_DIR;
                end
              end
              default: begin
                phase_nxt = phase_t'(5'(phase_r) + 5'd1);
              end
            endcase
          end
        end
      endcase

      // A blob that ends before done or an error is truncated.
      if (in_data.end_of_blob && !finished_nxt) begin
        if (res_n == 2'd0) begin
          res0 = error_beat(ERR_TRUNCATED);
        end else begin
          res1 = error_beat(ERR_TRUNCATED);
        end
        res_n = res_n + 2'd1;
      end
    end

    // Mark the final result of this byte.
    if (res_n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end

    // The last byte of a blob returns the parse to its starting point.
    if (in_accept && in_data.end_of_blob) begin
      phase_nxt      = PH_MAGIC;
      bif_nxt        = '0;
      acc_nxt        = '0;
      nodes_exp_nxt  = '0;
      nodes_seen_nxt = '0;
      chans_exp_nxt  = '0;
      chans_seen_nxt = '0;
      upd_exp_nxt    = '0;
      upd_seen_nxt   = '0;
      finished_nxt   = 1'b0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      bif_r        <= '0;
      acc_r        <= '0;
      nodes_exp_r  <= '0;
      nodes_seen_r <= '0;
      chans_exp_r  <= '0;
      chans_seen_r <= '0;
      upd_exp_r    <= '0;
      upd_seen_r   <= '0;
      finished_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bif_r        <= bif_nxt;
      acc_r        <= acc_nxt;
      nodes_exp_r  <= nodes_exp_nxt;
      nodes_seen_r <= nodes_seen_nxt;
      chans_exp_r  <= chans_exp_nxt;
      chans_seen_r <= chans_seen_nxt;
      upd_exp_r    <= upd_exp_nxt;
      upd_seen_r   <= upd_seen_nxt;
      finished_r   <= finished_nxt;
    end
  end

  // Result queue pointers and fill count.
  assign count_nxt = count_r + CntW'(res_n) - CntW'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(res_n);
      rd_ptr_r <= rd_ptr_r + PtrW'(out_pop);
      count_r  <= count_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (res_n == 2'd2) begin
      queue_r[wr_ptr_r + PtrW'(1)] <= res1;
    end
  end

endmodule
